[rtl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants of the row record decoder: result kinds,
// configuration register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rrd_pkg;

    // Widest schema the decoder holds
    localparam int MAX_COLUMNS = 32;

    // Configuration register indexes
    localparam logic CFG_COLUMN_COUNT = 1'b0;
    localparam logic CFG_COLUMN_TYPES = 1'b1;

    // Column type codes, two bits per column in the types register
    localparam logic [1:0] TYPE_INT   = 2'd0;
    localparam logic [1:0] TYPE_FLOAT = 2'd1;
    localparam logic [1:0] TYPE_BOOL  = 2'd2;
    localparam logic [1:0] TYPE_TEXT  = 2'd3;

    // Kind of an output word
    typedef enum logic [2:0] {
        KIND_NULL       = 3'd0,
        KIND_INT        = 3'd1,
        KIND_FLOAT      = 3'd2,
        KIND_BOOL       = 3'd3,
        KIND_TEXT_HDR   = 3'd4,
        KIND_TEXT_BYTE  = 3'd5,
        KIND_ROW_OK     = 3'd6,
        KIND_ROW_TRUNC  = 3'd7
    } kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // capture the input word
        logic walk;       // one column-walk step (null emit or field start)
        logic consume;    // apply the held byte to the current field
        logic end_item;   // emit the end-of-record word and clear parse state
        logic flush;      // move the held result out as last of run
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pre_walk;      // bitmap already complete, walk before consuming
        logic walk_done;     // walk step lands on a field or on row done
        logic consume_walk;  // consuming the byte ends a column or the bitmap
        logic out_free;      // output register can take a word this cycle
        logic rec_last;      // held byte carries the record end mark
    } dp_status_t;

endpackage

[rtl/row_record_decoder.sv]
// ----------------------------------------------------------------------------
// row_record_decoder
// Byte-serial parser of stored table rows: null bitmap, then little-endian
// integer, float, bool and length-prefixed text fields, one word per column
// or text byte plus an end-of-record word.
// ----------------------------------------------------------------------------
// The decoder takes one row byte at a time and works on it alone before it
// takes the next. A byte that ends no column and carries no record end mark
// goes through accept, consume and finish. Where the byte closes the bitmap
// or a column, a column walk follows that reports each null column and then
// opens the next field or marks the row done; the same walk runs before
// consuming when the row schema shrank under a finished bitmap. A byte with
// the record end mark also gets an end-of-record word before its flush. Each
// output word passes through a one-word hold stage so that the last word of
// a byte can be marked; the sequencer waits whenever the output register is
// full and stalled. Column count above 32 is read as 32. Configuration is
// written through cfg_write_en, cfg_index and cfg_data while the decoder is
// idle. The decoder itself does not enforce this.
// ----------------------------------------------------------------------------
module row_record_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        record_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  item_kind,
    output logic [4:0]  column_index,
    output logic [63:0] item_value,
    output logic        last_of_run
);

    rrd_pkg::dp_cmd_t    cmd;
    rrd_pkg::dp_status_t status;

    // Per-byte sequencer
    rrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Parse state and result path
    rrd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .record_end   (record_end),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .item_kind    (item_kind),
        .column_index (column_index),
        .item_value   (item_value),
        .last_of_run  (last_of_run)
    );

endmodule

[rtl/rrd_ctrl.sv]
// ----------------------------------------------------------------------------
// rrd_ctrl
// Per-byte sequencer: accepts one byte, runs the column walk before and
// after consuming it, emits the end-of-record word and flushes the last
// result of the byte.
// ----------------------------------------------------------------------------
module rrd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rrd_pkg::dp_status_t status,
    output rrd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE_WALK,
        S_CONSUME,
        S_POST_WALK,
        S_FINISH,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = status.pre_walk ? S_PRE_WALK : S_CONSUME;
                end
            end
            S_PRE_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.walk = 1'b1;
                    if (status.walk_done)
                    begin
                        state_next = S_CONSUME;
                    end
                end
            end
            S_CONSUME:
            begin
                if (status.out_free)
                begin
                    cmd.consume = 1'b1;
                    state_next  = status.consume_walk ? S_POST_WALK : S_FINISH;
                end
            end
            S_POST_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.walk = 1'b1;
                    if (status.walk_done)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    if (status.rec_last)
                    begin
                        cmd.end_item = 1'b1;
                        state_next   = S_FLUSH;
                    end
                    else
                    begin
                        cmd.flush  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the input stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

[rtl/rrd_datapath.sv]
// ----------------------------------------------------------------------------
// rrd_datapath
// Configuration registers, row parse state, field accumulator, a one-word
// hold stage that lets the last result of a byte be marked, and the output
// register.
// ----------------------------------------------------------------------------
module rrd_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic [7:0]          data_byte,
    input  logic                record_end,
    input  logic                out_stall,
    input  rrd_pkg::dp_cmd_t    cmd,
    output rrd_pkg::dp_status_t status,
    output logic                out_valid,
    output logic [2:0]          item_kind,
    output logic [4:0]          column_index,
    output logic [63:0]         item_value,
    output logic                last_of_run
);

    typedef enum logic [2:0] {
        PH_BITMAP = 3'd0,
        PH_INT    = 3'd1,
        PH_FLOAT  = 3'd2,
        PH_BOOL   = 3'd3,
        PH_LEN    = 3'd4,
        PH_TEXT   = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    localparam logic [5:0] MAX_COLS = 6'(rrd_pkg::MAX_COLUMNS);

    // Configuration
    logic [5:0]  column_count_reg;
    logic [63:0] column_types_reg;

    // Held input word
    logic [7:0]  byte_reg,  byte_next;
    logic        last_reg,  last_next;

    // Parse state
    phase_t      phase_reg,  phase_next;
    logic [31:0] bitmap_reg, bitmap_next;
    logic [2:0]  bm_cnt_reg, bm_cnt_next;
    logic [5:0]  col_reg,    col_next;
    logic [31:0] fcnt_reg,   fcnt_next;
    logic [63:0] acc_reg,    acc_next;
    logic [31:0] tlen_reg,   tlen_next;

    // Hold stage and output register
    logic                pend_valid_reg, pend_valid_next;
    rrd_pkg::kind_t      pend_kind_reg,  pend_kind_next;
    logic [4:0]          pend_col_reg,   pend_col_next;
    logic [63:0]         pend_value_reg, pend_value_next;
    logic                out_valid_reg,  out_valid_next;
    rrd_pkg::kind_t      out_kind_reg,   out_kind_next;
    logic [4:0]          out_col_reg,    out_col_next;
    logic [63:0]         out_value_reg,  out_value_next;
    logic                out_last_reg,   out_last_next;

    // Derived values
    logic [5:0]  eff_cols;
    logic [2:0]  bm_bytes;
    logic [3:0]  bm_cnt_inc;
    logic [4:0]  col_idx;
    logic        col_active;
    logic        col_null;
    logic [1:0]  col_type;
    phase_t      type_phase;
    logic [32:0] fcnt_inc;
    logic [63:0] acc_merge;
    logic        consume_walk;

    // New result of this cycle
    logic           em_valid;
    rrd_pkg::kind_t em_kind;
    logic [63:0]    em_value;

    // Schema size and current column
    always_comb
    begin
        eff_cols   = (column_count_reg > MAX_COLS) ? MAX_COLS : column_count_reg;
        bm_bytes   = 3'((eff_cols + 6'd7) >> 3);
        bm_cnt_inc = {1'b0, bm_cnt_reg} + 4'd1;
        col_idx    = col_reg[4:0];
        col_active = (col_reg < eff_cols);
        col_null   = bitmap_reg[col_idx];
        col_type   = column_types_reg[{col_idx, 1'b0} +: 2];
        fcnt_inc   = {1'b0, fcnt_reg} + 33'd1;
        acc_merge  = acc_reg | ({56'd0, byte_reg} << {fcnt_reg[2:0], 3'b000});
    end

    // Map a column type to its field phase
    always_comb
    begin
        unique case (col_type)
            rrd_pkg::TYPE_INT:   type_phase = PH_INT;
            rrd_pkg::TYPE_FLOAT: type_phase = PH_FLOAT;
            rrd_pkg::TYPE_BOOL:  type_phase = PH_BOOL;
            rrd_pkg::TYPE_TEXT:  type_phase = PH_LEN;
            default:             type_phase = PH_LEN;
        endcase
    end

    // Tell whether consuming the held byte closes the bitmap or a column
    always_comb
    begin
        unique case (phase_reg)
            PH_BITMAP:         consume_walk = (bm_cnt_inc >= {1'b0, bm_bytes});
            PH_INT, PH_FLOAT:  consume_walk = (fcnt_inc >= 33'd8);
            PH_BOOL:           consume_walk = 1'b1;
            PH_LEN:            consume_walk = (fcnt_inc >= 33'd4) &&
                                              (acc_merge[31:0] == 32'd0);
            PH_TEXT:           consume_walk = (fcnt_inc >= {1'b0, tlen_reg});
            default:           consume_walk = 1'b0;
        endcase
    end

    // Status to the controller
    always_comb
    begin
        status.pre_walk     = (phase_reg == PH_BITMAP) && (bm_cnt_reg >= bm_bytes);
        status.walk_done    = !col_active || !col_null;
        status.consume_walk = consume_walk;
        status.out_free     = !out_valid_reg || !out_stall;
        status.rec_last     = last_reg;
    end

    // Parse state update and result generation
    always_comb
    begin
        byte_next   = byte_reg;
        last_next   = last_reg;
        phase_next  = phase_reg;
        bitmap_next = bitmap_reg;
        bm_cnt_next = bm_cnt_reg;
        col_next    = col_reg;
        fcnt_next   = fcnt_reg;
        acc_next    = acc_reg;
        tlen_next   = tlen_reg;
        em_valid    = 1'b0;
        em_kind     = rrd_pkg::KIND_NULL;
        em_value    = 64'd0;

        // Capture the input word
        if (cmd.latch)
        begin
            byte_next = data_byte;
            last_next = record_end;
        end

        // Walk one column: emit a null or start the next field
        if (cmd.walk)
        begin
            if (!col_active)
            begin
                phase_next = PH_DONE;
            end
            else if (col_null)
            begin
                em_valid = 1'b1;
                em_kind  = rrd_pkg::KIND_NULL;
                col_next = col_reg + 6'd1;
            end
            else
            begin
                phase_next = type_phase;
                fcnt_next  = 32'd0;
                acc_next   = 64'd0;
            end
        end

        // Apply the held byte to the current field
        if (cmd.consume)
        begin
            unique case (phase_reg)
                PH_BITMAP:
                begin
                    bitmap_next = bitmap_reg |
                                  ({24'd0, byte_reg} << {bm_cnt_reg[1:0], 3'b000});
                    bm_cnt_next = bm_cnt_inc[2:0];
                end
                PH_INT, PH_FLOAT:
                begin
                    acc_next  = acc_merge;
                    fcnt_next = fcnt_inc[31:0];
                    if (consume_walk)
                    begin
                        em_valid = 1'b1;
                        em_kind  = (phase_reg == PH_INT) ? rrd_pkg::KIND_INT
                                                         : rrd_pkg::KIND_FLOAT;
                        em_value = acc_merge;
                        col_next = col_reg + 6'd1;
                    end
                end
                PH_BOOL:
                begin
                    em_valid = 1'b1;
                    em_kind  = rrd_pkg::KIND_BOOL;
                    em_value = {63'd0, (byte_reg != 8'd0)};
                    col_next = col_reg + 6'd1;
                end
                PH_LEN:
                begin
                    acc_next  = acc_merge;
                    fcnt_next = fcnt_inc[31:0];
                    if (fcnt_inc >= 33'd4)
                    begin
                        tlen_next = acc_merge[31:0];
                        em_valid  = 1'b1;
                        em_kind   = rrd_pkg::KIND_TEXT_HDR;
                        em_value  = {32'd0, acc_merge[31:0]};
                        if (consume_walk)
                        begin
                            col_next = col_reg + 6'd1;
                        end
                        else
                        begin
                            phase_next = PH_TEXT;
                            fcnt_next  = 32'd0;
                        end
                    end
                end
                PH_TEXT:
                begin
                    em_valid  = 1'b1;
                    em_kind   = rrd_pkg::KIND_TEXT_BYTE;
                    em_value  = {56'd0, byte_reg};
                    fcnt_next = fcnt_inc[31:0];
                    if (consume_walk)
                    begin
                        col_next = col_reg + 6'd1;
                    end
                end
                default:
                begin
                    // row complete: drop extra bytes
                end
            endcase
        end

        // Emit the end-of-record word and clear the parse state
        if (cmd.end_item)
        begin
            em_valid    = 1'b1;
            em_kind     = (phase_reg == PH_DONE) ? rrd_pkg::KIND_ROW_OK
                                                 : rrd_pkg::KIND_ROW_TRUNC;
            em_value    = 64'd0;
            phase_next  = PH_BITMAP;
            bitmap_next = 32'd0;
            bm_cnt_next = 3'd0;
            col_next    = 6'd0;
            fcnt_next   = 32'd0;
            acc_next    = 64'd0;
            tlen_next   = 32'd0;
        end
    end

    // Hold stage and output register movement
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_col_next   = pend_col_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_col_next    = out_col_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        // Push the held word out and hold the new one
        if (em_valid)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_col_next   = pend_col_reg;
                out_value_next = pend_value_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = em_kind;
            pend_col_next   = ((em_kind == rrd_pkg::KIND_ROW_OK) ||
                               (phase_reg == PH_BITMAP && cmd.end_item)) ? 5'd0 : col_idx;
            pend_value_next = em_value;
        end
        else if (cmd.flush && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_col_next    = pend_col_reg;
            out_value_next  = pend_value_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 6'd0;
            column_types_reg <= 64'd0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rrd_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data[5:0];
                rrd_pkg::CFG_COLUMN_TYPES: column_types_reg <= cfg_data;
                default:                   column_types_reg <= column_types_reg;
            endcase
        end
    end

    // Parse state and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BITMAP;
            bitmap_reg     <= 32'd0;
            bm_cnt_reg     <= 3'd0;
            col_reg        <= 6'd0;
            fcnt_reg       <= 32'd0;
            acc_reg        <= 64'd0;
            tlen_reg       <= 32'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bitmap_reg     <= bitmap_next;
            bm_cnt_reg     <= bm_cnt_next;
            col_reg        <= col_next;
            fcnt_reg       <= fcnt_next;
            acc_reg        <= acc_next;
            tlen_reg       <= tlen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        pend_kind_reg  <= pend_kind_next;
        pend_col_reg   <= pend_col_next;
        pend_value_reg <= pend_value_next;
        out_kind_reg   <= out_kind_next;
        out_col_reg    <= out_col_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign item_kind    = out_kind_reg;
    assign column_index = out_col_reg;
    assign item_value   = out_value_reg;
    assign last_of_run  = out_last_reg;

endmodule

[rtl/rrd_checker.sv]
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks of the row record decoder, attached by bind.
// ----------------------------------------------------------------------------
module rrd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write_en,
    input logic        cfg_index,
    input logic [63:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        record_end,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  item_kind,
    input logic [4:0]  column_index,
    input logic [63:0] item_value,
    input logic        last_of_run
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(item_kind) &&
            $stable(column_index) && $stable(item_value) && $stable(last_of_run))
        else $error("stalled output word changed");

    // One byte at a time: stall right after an accepted word
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // End-of-record words close the run of their byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == rrd_pkg::KIND_ROW_OK ||
                      item_kind == rrd_pkg::KIND_ROW_TRUNC) |-> last_of_run)
        else $error("end-of-record word not marked last");

    // Row ok carries column zero and no value
    a_row_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == rrd_pkg::KIND_ROW_OK |->
            column_index == 5'd0 && item_value == 64'd0)
        else $error("row ok word has column or value");

    // Null and bool values stay in range
    a_small_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == rrd_pkg::KIND_NULL ||
                      item_kind == rrd_pkg::KIND_BOOL) |-> item_value[63:1] == 63'd0)
        else $error("null or bool word out of range");

endmodule

bind row_record_decoder rrd_checker u_rrd_checker (.*);
